[design/tet_pkg.sv]
package tet_pkg;

    localparam int COORD_W = 12;
    localparam int Z_W     = 8;
    localparam int DXY_W   = 13;
    localparam int DZ_W    = 9;
    localparam int TMO_W   = 16;
    localparam int CNT_W   = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_IRQ        = 2'd1,
        ACT_READ_TOUCH = 2'd2,
        ACT_READ_DRAG  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_UNTOUCHED = 2'd0,
        MODE_TOUCHED   = 2'd1,
        MODE_HOLDOFF   = 2'd2
    } mode_t;

    typedef enum logic {
        CFG_HOLD_TIMEOUT = 1'b0,
        CFG_DRAG_TIMEOUT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        action_t           action;
        logic              touch_detect_event;
        logic              touch_present;
        logic              fifo_data_event;
        logic [CNT_W-1:0]  fifo_count;
        logic [7:0]        sample_byte_hi;
        logic [7:0]        sample_byte_mid;
        logic [7:0]        sample_byte_lo;
    } item_t;

    typedef struct packed {
        logic                     touch_valid;
        logic [COORD_W-1:0]       touch_x;
        logic [COORD_W-1:0]       touch_y;
        logic [Z_W-1:0]           touch_z;
        logic                     drag_valid;
        logic signed [DXY_W-1:0]  drag_dx;
        logic signed [DXY_W-1:0]  drag_dy;
        logic signed [DZ_W-1:0]   drag_dz;
        logic                     detector_touched;
        mode_t                    tracking_mode;
    } result_t;

endpackage

[design/tet_in_stage.sv]
module tet_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tet_pkg::item_t in_item,
    input  logic          advance,
    output logic          item_valid,
    output tet_pkg::item_t item
);
    import tet_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

[design/tet_core.sv]
module tet_core
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  tet_pkg::cfg_index_t          cfg_index,
    input  logic [tet_pkg::TMO_W-1:0]    cfg_data,
    input  logic                         fire,
    input  tet_pkg::item_t               item,
    output tet_pkg::result_t             result
);
    import tet_pkg::*;

    logic [TMO_W-1:0]     hold_tmo_reg;
    logic [TMO_W-1:0]     drag_tmo_reg;
    mode_t                mode_reg, mode_next;
    logic                 det_reg, det_next;
    logic                 latched_reg, latched_next;
    logic [COORD_W-1:0]   lat_x_reg, lat_x_next, lat_y_reg, lat_y_next;
    logic [COORD_W-1:0]   drag_x_reg, drag_x_next, drag_y_reg, drag_y_next;
    logic [COORD_W-1:0]   new_x_reg, new_x_next, new_y_reg, new_y_next;
    logic                 fresh_reg, fresh_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] hold_dl_reg, hold_dl_next;
    logic [TIME_BITS-1:0] drag_dl_reg, drag_dl_next;

    logic [TIME_BITS-1:0] hold_later, drag_later;
    logic [COORD_W-1:0]   smp_x, smp_y;
    logic                 take_sample;

    assign hold_later  = now_reg + TIME_BITS'(hold_tmo_reg);
    assign drag_later  = now_reg + TIME_BITS'(drag_tmo_reg);
    assign smp_x       = {item.sample_byte_hi, item.sample_byte_mid[7:4]};
    assign smp_y       = {item.sample_byte_mid[3:0], item.sample_byte_lo};
    assign take_sample = item.fifo_data_event && (item.fifo_count != '0);

    always_comb
    begin
        mode_next    = mode_reg;
        det_next     = det_reg;
        latched_next = latched_reg;
        lat_x_next   = lat_x_reg;
        lat_y_next   = lat_y_reg;
        drag_x_next  = drag_x_reg;
        drag_y_next  = drag_y_reg;
        new_x_next   = new_x_reg;
        new_y_next   = new_y_reg;
        fresh_next   = fresh_reg;
        now_next     = now_reg;
        hold_dl_next = hold_dl_reg;
        drag_dl_next = drag_dl_reg;

        result = '0;

        case (item.action)
            ACT_TICK:
            begin
                now_next = now_reg + TIME_BITS'(1);
            end
            ACT_IRQ:
            begin
                if (item.touch_detect_event)
                begin
                    det_next = item.touch_present;
                end
                if (mode_reg == MODE_HOLDOFF)
                begin
                    if ((hold_dl_reg < now_reg) && !latched_reg)
                    begin
                        mode_next = det_next ? MODE_TOUCHED : MODE_UNTOUCHED;
                    end
                    else if (det_next)
                    begin
                        // keep pushing the hold-off out while touched
                        hold_dl_next = hold_later;
                    end
                end
                else
                begin
                    latched_next = 1'b0;
                    mode_next    = det_next ? MODE_TOUCHED : MODE_UNTOUCHED;
                end
                if (take_sample)
                begin
                    new_x_next   = smp_x;
                    new_y_next   = smp_y;
                    fresh_next   = 1'b1;
                    drag_dl_next = drag_later;
                    if (mode_next != MODE_HOLDOFF)
                    begin
                        latched_next = 1'b1;
                        lat_x_next   = smp_x;
                        lat_y_next   = smp_y;
                        drag_x_next  = smp_x;
                        drag_y_next  = smp_y;
                        hold_dl_next = hold_later;
                        mode_next    = MODE_HOLDOFF;
                    end
                end
            end
            ACT_READ_TOUCH:
            begin
                latched_next = 1'b0;
            end
            ACT_READ_DRAG:
            begin
                if (fresh_reg && (mode_reg == MODE_HOLDOFF))
                begin
                    result.drag_valid = 1'b1;
                    result.drag_dx    = {1'b0, new_x_reg} - {1'b0, drag_x_reg};
                    result.drag_dy    = {1'b0, new_y_reg} - {1'b0, drag_y_reg};
                    result.drag_dz    = {1'b0, new_y_reg[Z_W-1:0]}
                                      - {1'b0, drag_y_reg[Z_W-1:0]};
                    drag_x_next = new_x_reg;
                    drag_y_next = new_y_reg;
                    fresh_next  = 1'b0;
                end
                else
                begin
                    result.drag_valid = drag_dl_reg > now_reg;
                end
            end
            default:
            begin
            end
        endcase

        // touch read shows the latch as it stood before clearing
        result.touch_valid      = (item.action == ACT_READ_TOUCH) ? latched_reg
                                                                  : latched_next;
        result.touch_x          = lat_x_next;
        result.touch_y          = lat_y_next;
        result.touch_z          = lat_y_next[Z_W-1:0];
        result.detector_touched = det_next;
        result.tracking_mode    = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_tmo_reg <= TMO_W'(20);
            drag_tmo_reg <= TMO_W'(100);
            mode_reg     <= MODE_HOLDOFF;
            det_reg      <= 1'b0;
            latched_reg  <= 1'b0;
            lat_x_reg    <= '0;
            lat_y_reg    <= '0;
            drag_x_reg   <= '0;
            drag_y_reg   <= '0;
            new_x_reg    <= '0;
            new_y_reg    <= '0;
            fresh_reg    <= 1'b0;
            now_reg      <= '0;
            hold_dl_reg  <= '0;
            drag_dl_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HOLD_TIMEOUT: hold_tmo_reg <= cfg_data;
                    CFG_DRAG_TIMEOUT: drag_tmo_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (fire)
            begin
                mode_reg    <= mode_next;
                det_reg     <= det_next;
                latched_reg <= latched_next;
                lat_x_reg   <= lat_x_next;
                lat_y_reg   <= lat_y_next;
                drag_x_reg  <= drag_x_next;
                drag_y_reg  <= drag_y_next;
                new_x_reg   <= new_x_next;
                new_y_reg   <= new_y_next;
                fresh_reg   <= fresh_next;
                now_reg     <= now_next;
                hold_dl_reg <= hold_dl_next;
                drag_dl_reg <= drag_dl_next;
            end
        end
    end

endmodule

[design/tet_out_stage.sv]
module tet_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    output logic             res_ready,
    input  tet_pkg::result_t res,
    output logic             out_valid,
    input  logic             out_ready,
    output tet_pkg::result_t out_res
);
    import tet_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

[design/touch_event_tracker.sv]
// touch event tracker: every input transaction (a millisecond tick, a controller
// interrupt with its status flags and newest 3-byte sample, a touch read or a drag
// read) yields exactly one output transaction carrying the latched touch, the drag
// result, the detector state and the tracking mode. a transaction is registered on
// input, the tracker state is updated by a single level of logic, and the result
// is registered on output, so the block takes one transaction per clock cycle
// while the output is not stalled; a result moves from the input register to the
// output register once the output register can take it. time is a free-running
// TIME_BITS-wide millisecond count advanced only by tick transactions; deadlines
// wrap with it and are compared unsigned.
// configuration writes (hold-off and drag timeouts) take effect at once and are
// meant to be issued while no transaction is in flight.
module touch_event_tracker
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [15:0]                       cfg_data,

    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action
    input  logic [1:0]                        s_axis_tuser,
    // touch_detect_event, touch_present, fifo_data_event, fifo_count,
    // sample_byte_hi, sample_byte_mid, sample_byte_lo, zero pad
    input  logic [tet_pkg::IN_DATA_W-1:0]     s_axis_tdata,

    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // touch_valid, touch_x, touch_y, touch_z, drag_valid, drag_dx, drag_dy,
    // drag_dz, detector_touched, tracking_mode
    output logic [tet_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import tet_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    res_ready;
    logic    fire;
    result_t res;
    result_t out_res;

    // unpack the input transaction
    assign in_item.action             = action_t'(s_axis_tuser);
    assign in_item.touch_detect_event = s_axis_tdata[0];
    assign in_item.touch_present      = s_axis_tdata[1];
    assign in_item.fifo_data_event    = s_axis_tdata[2];
    assign in_item.fifo_count         = s_axis_tdata[10:3];
    assign in_item.sample_byte_hi     = s_axis_tdata[18:11];
    assign in_item.sample_byte_mid    = s_axis_tdata[26:19];
    assign in_item.sample_byte_lo     = s_axis_tdata[34:27];

    // state moves only when the item can hand its result to the output register
    assign fire = item_valid && res_ready;

    tet_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (res_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    tet_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (res)
    );

    tet_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // pack the result, first field in the lowest bits
    assign m_axis_tdata = {
        out_res.tracking_mode,
        out_res.detector_touched,
        out_res.drag_dz,
        out_res.drag_dy,
        out_res.drag_dx,
        out_res.drag_valid,
        out_res.touch_z,
        out_res.touch_y,
        out_res.touch_x,
        out_res.touch_valid
    };

endmodule

[tb/testbench.sv]
module testbench;

    import tet_pkg::*;

    // watchdog: far above the slowest correct run (~1200 transactions, each with
    // long sender gaps and long output stalls)
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [Z_W-1:0]     z;
    } point_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   cfg_we = 1'b0;
    logic                   cfg_index = CFG_HOLD_TIMEOUT;
    logic [TMO_W-1:0]       cfg_data = '0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // action
    logic [1:0]             s_axis_tuser = ACT_TICK;
    // touch_detect_event, touch_present, fifo_data_event, fifo_count,
    // sample_byte_hi, sample_byte_mid, sample_byte_lo, zero pad
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // touch_valid, touch_x, touch_y, touch_z, drag_valid, drag_dx, drag_dy,
    // drag_dz, detector_touched, tracking_mode
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    touch_event_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // tracker state as the testbench sees it
    // ------------------------------------------------------------------
    logic [TMO_W-1:0]   hold_ms;
    logic [TMO_W-1:0]   drag_ms;
    mode_t              cur_mode;
    logic               det_touched;
    logic               touch_latched;
    point_t             latched_pt;
    point_t             anchor_pt;      // last drag point
    point_t             newest_pt;
    logic               newest_fresh;
    logic [31:0]        now_ms;
    logic [31:0]        hold_until;
    logic [31:0]        drag_until;

    result_t            expected_reports[$];

    int                 idle_pct = 0;   // sender idle chance per cycle
    int                 stall_pct = 0;  // receiver stall chance per cycle
    int                 items_sent = 0;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // advance the tracker by one transaction and return the report it must produce
    function automatic result_t track_touch(input item_t it);
        result_t r;
        r = '0;
        case (it.action)
            ACT_TICK:
            begin
                now_ms = now_ms + 32'd1;
            end
            ACT_IRQ:
            begin
                if (it.touch_detect_event)
                    det_touched = it.touch_present;
                if (cur_mode == MODE_HOLDOFF)
                begin
                    // leave hold-off only once the deadline has passed and the
                    // latched touch has been read
                    if (hold_until < now_ms && !touch_latched)
                        cur_mode = det_touched ? MODE_TOUCHED : MODE_UNTOUCHED;
                    else if (det_touched)
                        hold_until = now_ms + hold_ms;
                end
                else
                begin
                    touch_latched = 1'b0;
                    cur_mode = det_touched ? MODE_TOUCHED : MODE_UNTOUCHED;
                end
                // a fifo flag with an empty fifo brings no sample
                if (it.fifo_data_event && it.fifo_count != '0)
                begin
                    newest_pt.x = {it.sample_byte_hi, it.sample_byte_mid[7:4]};
                    newest_pt.y = {it.sample_byte_mid[3:0], it.sample_byte_lo};
                    newest_pt.z = it.sample_byte_lo;   // z is the low byte of y
                    newest_fresh = 1'b1;
                    drag_until = now_ms + drag_ms;
                    if (cur_mode != MODE_HOLDOFF)
                    begin
                        touch_latched = 1'b1;
                        latched_pt = newest_pt;
                        anchor_pt = newest_pt;
                        hold_until = now_ms + hold_ms;
                        cur_mode = MODE_HOLDOFF;
                    end
                end
            end
            default:
            begin
            end
        endcase

        r.touch_valid = touch_latched;
        r.touch_x = latched_pt.x;
        r.touch_y = latched_pt.y;
        r.touch_z = latched_pt.z;

        if (it.action == ACT_READ_TOUCH)
        begin
            touch_latched = 1'b0;
        end
        else if (it.action == ACT_READ_DRAG)
        begin
            if (newest_fresh && cur_mode == MODE_HOLDOFF)
            begin
                r.drag_valid = 1'b1;
                r.drag_dx = {1'b0, newest_pt.x} - {1'b0, anchor_pt.x};
                r.drag_dy = {1'b0, newest_pt.y} - {1'b0, anchor_pt.y};
                r.drag_dz = {1'b0, newest_pt.z} - {1'b0, anchor_pt.z};
                anchor_pt = newest_pt;
                newest_fresh = 1'b0;
            end
            else
            begin
                // no fresh movement: valid while the drag timeout runs
                r.drag_valid = (drag_until > now_ms);
            end
        end

        r.detector_touched = det_touched;
        r.tracking_mode = cur_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("report %0d: %s is %0d, should be %0d", results_seen, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls and the check of every output transaction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t want;
        logic [OUT_DATA_W-1:0] d;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            d = m_axis_tdata;
            if (expected_reports.size() == 0)
            begin
                report_mismatch("unexpected transaction", 1, 0);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (d[0] !== want.touch_valid)
                    report_mismatch("touch_valid", d[0], want.touch_valid);
                if (d[12:1] !== want.touch_x)
                    report_mismatch("touch_x", d[12:1], want.touch_x);
                if (d[24:13] !== want.touch_y)
                    report_mismatch("touch_y", d[24:13], want.touch_y);
                if (d[32:25] !== want.touch_z)
                    report_mismatch("touch_z", d[32:25], want.touch_z);
                if (d[33] !== want.drag_valid)
                    report_mismatch("drag_valid", d[33], want.drag_valid);
                if (d[46:34] !== want.drag_dx)
                    report_mismatch("drag_dx", $signed(d[46:34]), want.drag_dx);
                if (d[59:47] !== want.drag_dy)
                    report_mismatch("drag_dy", $signed(d[59:47]), want.drag_dy);
                if (d[68:60] !== want.drag_dz)
                    report_mismatch("drag_dz", $signed(d[68:60]), want.drag_dz);
                if (d[69] !== want.detector_touched)
                    report_mismatch("detector_touched", d[69], want.detector_touched);
                if (d[71:70] !== want.tracking_mode)
                    report_mismatch("tracking_mode", d[71:70], want.tracking_mode);
            end
            results_seen++;
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_item(input item_t it);
        // random idle cycles ahead of the transaction
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {5'b0, it.sample_byte_lo, it.sample_byte_mid, it.sample_byte_hi,
                          it.fifo_count, it.fifo_data_event, it.touch_present,
                          it.touch_detect_event};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_reports.push_back(track_touch(it));
        items_sent++;
    endtask

    // hold the input until every outstanding report is back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // only called while nothing is in flight
    task automatic write_timeouts(input logic [TMO_W-1:0] hold, input logic [TMO_W-1:0] drag);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HOLD_TIMEOUT;
        cfg_data  <= hold;
        @(posedge clk);
        hold_ms = hold;
        cfg_index <= CFG_DRAG_TIMEOUT;
        cfg_data  <= drag;
        @(posedge clk);
        drag_ms = drag;
        cfg_we <= 1'b0;
    endtask

    // transaction of the given action with random fields, junk for a tick or read
    function automatic item_t plain_item(input action_t a);
        item_t it;
        it = item_t'({$urandom, $urandom});
        it.action = a;
        return it;
    endfunction

    function automatic item_t irq_item(input logic det_ev, input logic present,
                                       input logic fifo_ev, input logic [CNT_W-1:0] cnt,
                                       input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y);
        item_t it;
        it.action             = ACT_IRQ;
        it.touch_detect_event = det_ev;
        it.touch_present      = present;
        it.fifo_data_event    = fifo_ev;
        it.fifo_count         = cnt;
        it.sample_byte_hi     = x[11:4];
        it.sample_byte_mid    = {x[3:0], y[11:8]};
        it.sample_byte_lo     = y[7:0];
        return it;
    endfunction

    // mostly a normal fill, sometimes empty, sometimes beyond the fifo depth
    function automatic logic [CNT_W-1:0] fifo_fill();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CNT_W'($urandom_range(129, 255));
            default: return CNT_W'($urandom_range(1, 128));
        endcase
    endfunction

    task automatic tick_burst(input int n);
        repeat (n)
            send_item(plain_item(ACT_TICK));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset timeouts, coordinate extremes, empty fifo and oversized count
    task automatic test_default_timeouts();
        send_item(plain_item(ACT_TICK));
        send_item(irq_item(1'b1, 1'b1, 1'b1, 8'd1, 12'h000, 12'h000));
        send_item(irq_item(1'b0, 1'b1, 1'b1, 8'd128, 12'hfff, 12'hfff));
        send_item(plain_item(ACT_READ_DRAG));     // largest positive movement
        send_item(plain_item(ACT_READ_TOUCH));
        send_item(irq_item(1'b0, 1'b0, 1'b1, 8'd0, 12'h4d2, 12'h3a9));
        send_item(irq_item(1'b1, 1'b1, 1'b1, 8'd255, 12'h000, 12'h000));
        send_item(plain_item(ACT_READ_DRAG));     // largest negative movement
        send_item(plain_item(ACT_READ_DRAG));     // no fresh sample, timeout running
        send_item(plain_item(ACT_READ_TOUCH));    // nothing latched any more
        wait_for_results();
    endtask

    // hold-off exit, drag read outside hold-off, drag timeout expiry,
    // and the unread latched touch blocking the exit
    task automatic test_holdoff_exit();
        write_timeouts(16'd0, 16'd2);
        send_item(irq_item(1'b1, 1'b1, 1'b1, 8'd3, 12'h5a3, 12'h1c7));
        send_item(plain_item(ACT_TICK));
        send_item(irq_item(1'b1, 1'b0, 1'b0, 8'd0, 12'h000, 12'h000));
        send_item(plain_item(ACT_READ_DRAG));     // fresh sample but mode untouched
        send_item(plain_item(ACT_TICK));
        send_item(plain_item(ACT_READ_DRAG));     // drag timeout just expired
        send_item(irq_item(1'b0, 1'b1, 1'b1, 8'd1, 12'hfff, 12'h000));
        send_item(plain_item(ACT_READ_DRAG));
        send_item(plain_item(ACT_TICK));
        send_item(irq_item(1'b0, 1'b0, 1'b0, 8'd0, 12'h000, 12'h000));
        send_item(plain_item(ACT_READ_TOUCH));
        send_item(irq_item(1'b0, 1'b0, 1'b0, 8'd0, 12'h000, 12'h000));
        wait_for_results();
    endtask

    // press, move, read and lift sequences with random content
    task automatic test_touch_gestures(input int target);
        logic [COORD_W-1:0] gx;
        logic [COORD_W-1:0] gy;
        int steps;
        int cap;
        while (items_sent < target)
        begin
            gx = COORD_W'($urandom);
            gy = COORD_W'($urandom);
            send_item(irq_item(1'b1, 1'b1, $urandom_range(0, 7) != 0, fifo_fill(), gx, gy));
            steps = $urandom_range(1, 10);
            repeat (steps)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            gx = COORD_W'($urandom);
                            gy = COORD_W'($urandom);
                        end
                        else
                        begin
                            gx = COORD_W'(gx + $urandom_range(0, 96) - 48);
                            gy = COORD_W'(gy + $urandom_range(0, 96) - 48);
                        end
                        send_item(irq_item(1'($urandom_range(0, 1)), 1'b1, 1'b1,
                                           fifo_fill(), gx, gy));
                    end
                    4, 5:    send_item(plain_item(ACT_READ_DRAG));
                    6:       send_item(plain_item(ACT_READ_TOUCH));
                    7, 8:    tick_burst($urandom_range(1, 4));
                    default: send_item(irq_item(1'($urandom_range(0, 1)), 1'b1, 1'b0,
                                                CNT_W'($urandom), COORD_W'($urandom),
                                                COORD_W'($urandom)));
                endcase
            end
            // lift, then let time run toward the hold-off deadline
            send_item(irq_item(1'b1, 1'b0, 1'($urandom_range(0, 1)), fifo_fill(), gx, gy));
            if ($urandom_range(0, 1))
                send_item(plain_item(ACT_READ_TOUCH));
            cap = (hold_ms > 28) ? 30 : hold_ms + 2;
            tick_burst($urandom_range(0, cap));
            if ($urandom_range(0, 5) == 0)
            begin
                // sometimes run past the drag timeout
                cap = (drag_ms > 110) ? 40 : drag_ms + 2;
                tick_burst($urandom_range(0, cap));
            end
            send_item(irq_item(1'($urandom_range(0, 1)), 1'b0, 1'b0, CNT_W'($urandom),
                               COORD_W'($urandom), COORD_W'($urandom)));
            send_item(plain_item(ACT_READ_DRAG));
            // now and then hold the input until the output has caught up
            if ($urandom_range(0, 19) == 0)
                wait_for_results();
        end
    endtask

    // unstructured transactions, all fields random
    task automatic test_stray_traffic(input int n);
        repeat (n)
            send_item(plain_item(action_t'($urandom_range(0, 3))));
    endtask

    task automatic run_phase(input int idle, input int stall,
                             input logic [TMO_W-1:0] hold, input logic [TMO_W-1:0] drag);
        idle_pct  = idle;
        stall_pct = stall;
        write_timeouts(hold, drag);
        test_touch_gestures(items_sent + 230);
        test_stray_traffic(45);
        wait_for_results();
    endtask

    initial
    begin
        hold_ms       = 16'd20;
        drag_ms       = 16'd100;
        cur_mode      = MODE_HOLDOFF;
        det_touched   = 1'b0;
        touch_latched = 1'b0;
        latched_pt    = '0;
        anchor_pt     = '0;
        newest_pt     = '0;
        newest_fresh  = 1'b0;
        now_ms        = '0;
        hold_until    = '0;
        drag_until    = '0;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timeouts();
        test_holdoff_exit();

        // pacing phases, each with its own timeouts (extremes included)
        run_phase(0, 0, 16'd20, 16'd100);
        run_phase(80, 0, 16'd0, 16'd0);
        run_phase(0, 80, 16'hffff, 16'hffff);
        run_phase(12, 12, 16'd4, 16'd25);

        wait_for_results();
        repeat (8)
            @(posedge clk);
        if (expected_reports.size() != 0)
            report_mismatch("reports still missing", 0, expected_reports.size());
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
